/* hw/rtl/mts_pkg.sv */
// Shared constants and types for the minimum-tracking stack.
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_MIN = '1;

  typedef struct packed {
    logic accept;
    logic load_top;
  } mts_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } mts_stat_t;

endpackage

/* hw/rtl/min_tracking_stack.sv */
// Top level of the minimum-tracking stack.
// Each transaction pushes a signed 32-bit value, pops the top entry or queries
// the minimum, and yields one result: the stack minimum after the operation
// (-1 when empty), an empty flag and a status (pop on empty ignored, push when
// full dropped). One transaction is handled at a time. The result is offered
// the cycle after acceptance for a push, a query or a pop that empties the
// stack or finds it empty. A pop that leaves at least one entry behind passes
// through a fetch state before offering its result, since the new top minimum
// comes from the store's registered read port. The next transaction is taken
// the cycle after the result is taken. The store needs no clearing after reset.
module min_tracking_stack (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mts_pkg::OP_W-1:0]          operation,
  input  logic signed [mts_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic                              is_empty,
  output logic [mts_pkg::STATUS_W-1:0]      status
);

  import mts_pkg::*;

  mts_cmd_t  cmd;
  mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mts_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .operation(operation),
    .value    (value),
    .min_value(min_value),
    .is_empty (is_empty),
    .status   (status)
  );

endmodule

/* hw/rtl/mts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mts_ctrl.sv */
// Controller state machine: sequences accept, top fetch and result delivery.
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mts_pkg::mts_stat_t stat,
  output mts_pkg::mts_cmd_t  cmd
);

  import mts_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.load_top = (state == S_FETCH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = stat.need_fetch ? S_FETCH : S_OUT;
        end
      end
      S_FETCH: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/mts_datapath.sv */
// Datapath: entry count, top minimum register, status and the minimum store.
module mts_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mts_pkg::mts_cmd_t                   cmd,
  output mts_pkg::mts_stat_t                  stat,
  input  logic [mts_pkg::OP_W-1:0]            operation,
  input  logic signed [mts_pkg::DATA_W-1:0]   value,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value,
  output logic                                is_empty,
  output logic [mts_pkg::STATUS_W-1:0]        status
);

  import mts_pkg::*;

  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic signed [DATA_W-1:0] top_min;
  logic signed [DATA_W-1:0] top_min_next;
  logic [STATUS_W-1:0]      status_next;
  logic [ADDR_W-1:0]        below_idx;
  logic signed [DATA_W-1:0] push_min;
  logic [DATA_W-1:0]        rdata;
  logic                     is_full;
  logic                     we;

  assign is_full   = (count == COUNT_W'(STACK_DEPTH));
  assign is_empty  = (count == '0);
  assign below_idx = count[ADDR_W-1:0] - ADDR_W'(2);
  assign push_min  = (!is_empty && (top_min < value)) ? top_min : value;
  assign we        = cmd.accept && (operation == OP_PUSH) && !is_full;

  assign stat.need_fetch = (operation == OP_POP) && (count > COUNT_W'(1));

  assign min_value = is_empty ? EMPTY_MIN : top_min;

  mts_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(push_min),
    .raddr(below_idx),
    .rdata(rdata)
  );

  always_comb begin
    count_next   = count;
    top_min_next = top_min;
    status_next  = status;
    if (cmd.accept) begin
      status_next = ST_DONE;
      unique case (operation)
        OP_PUSH: begin
          if (is_full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            count_next   = count + COUNT_W'(1);
            top_min_next = push_min;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            count_next = count - COUNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.load_top) begin
      top_min_next = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    top_min <= top_min_next;
    status  <= status_next;
  end

endmodule

/* hw/rtl/mts_checker.sv */
// Port-level checker for the minimum-tracking stack and its bind.
module mts_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [mts_pkg::OP_W-1:0]          operation,
  input logic signed [mts_pkg::DATA_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mts_pkg::DATA_W-1:0] min_value,
  input logic                              is_empty,
  input logic [mts_pkg::STATUS_W-1:0]      status
);

  import mts_pkg::*;

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> min_value == EMPTY_MIN)
    else $error("empty stack shows a minimum other than -1");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_POP_EMPTY |-> is_empty)
    else $error("pop on empty reported with entries held");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("second result without a new transaction");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid)
    else $error("transaction accepted while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_value) && $stable(status)
      && $stable(is_empty))
    else $error("stalled result changed");

endmodule

bind min_tracking_stack mts_props u_mts_props (.*);

/* test/mts_checker.sv */
`timescale 1ns / 100ps
// Checker for the minimum-tracking stack: predicts each result and compares it.
module mts_checker
  import mts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] min_value,
  input  logic                     is_empty,
  input  logic [STATUS_W-1:0]      status,
  output int                       fail_count,
  output int                       outstanding
);

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } stack_result_t;

  logic signed [DATA_W-1:0] running_min [STACK_DEPTH];
  int                       depth;
  stack_result_t            due_results [$];
  stack_result_t            head;
  int                       errors;
  int                       results_seen;

  initial begin
    depth        = 0;
    errors       = 0;
    results_seen = 0;
    fail_count   = 0;
    outstanding  = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  task automatic track_minimum(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    stack_result_t r;
    r.status = ST_DONE;
    case (op)
      OP_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          if (depth != 0 && running_min[depth-1] < v) running_min[depth] = running_min[depth-1];
          else running_min[depth] = v;
          depth++;
        end
      end
      OP_POP: begin
        if (depth == 0) r.status = ST_POP_EMPTY;
        else depth--;
      end
      default: begin
      end
    endcase
    r.min_value = (depth == 0) ? EMPTY_MIN : running_min[depth-1];
    r.is_empty  = (depth == 0);
    due_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) track_minimum(operation, value);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result with no transaction outstanding, min %0d", min_value));
        end else begin
          head = due_results.pop_front();
          if (min_value !== head.min_value)
            flag_mismatch($sformatf("min_value %0d, predicted %0d", min_value, head.min_value));
          if (is_empty !== head.is_empty)
            flag_mismatch($sformatf("is_empty %b, predicted %b", is_empty, head.is_empty));
          if (status !== head.status)
            flag_mismatch($sformatf("status %0d, predicted %0d", status, head.status));
        end
        results_seen++;
      end
    end
    outstanding <= due_results.size();
    fail_count  <= errors;
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the minimum-tracking stack testbench: clock, reset, stimulus and verdict.
module testbench;
  import mts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              RANDOM_ITEMS = 1800;
  localparam int              IDLE_LIMIT   = 1000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] min_value;
  logic                     is_empty;
  logic [STATUS_W-1:0]      status;
  int                       fail_count;
  int                       outstanding;
  logic                     calm;
  int                       stall_left;
  int                       idle_cycles;

  min_tracking_stack u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_value (min_value),
    .is_empty  (is_empty),
    .status    (status)
  );

  mts_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .min_value   (min_value),
    .is_empty    (is_empty),
    .status      (status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_QUERY;
    value       = '0;
    out_ready   = 1'b0;
    calm        = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
  end

  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_mode_t mode);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        push_pct = 80;
        pop_pct  = 8;
      end
      MODE_DRAIN: begin
        push_pct = 15;
        pop_pct  = 73;
      end
      default: begin
        push_pct = 46;
        pop_pct  = 42;
      end
    endcase
    if (r < push_pct) return OP_PUSH;
    if (r < push_pct + pop_pct) return OP_POP;
    if (r < 96) return OP_QUERY;
    return OP_UNUSED;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3, 4: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("min_tracking_stack: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int            sent;
    int            len;
    logic          quiet;
    traffic_mode_t mode;

    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_QUERY, 32'sd0, gap_len());
    send_item(OP_POP, 32'sd0, gap_len());
    send_item(OP_UNUSED, -32'sd1, 0);
    send_item(OP_PUSH, 32'sh7FFF_FFFF, 0);
    send_item(OP_PUSH, -32'sd1, gap_len());
    send_item(OP_PUSH, -32'sd1, 0);
    send_item(OP_PUSH, 32'sh8000_0000, 0);
    send_item(OP_PUSH, 32'sh8000_0000, gap_len());
    send_item(OP_QUERY, 32'sh5555_5555, 0);
    send_item(OP_UNUSED, 32'shAAAA_AAAA, 0);
    repeat (4) send_item(OP_POP, -32'sd1, gap_len());
    send_item(OP_POP, 32'sd0, 0);
    send_item(OP_POP, 32'sd0, 0);
    send_item(OP_PUSH, -32'sd1, 0);
    send_item(OP_POP, 32'sd0, gap_len());
    send_item(OP_PUSH, 32'sd0, 0);
    send_item(OP_PUSH, 32'sh5555_5555, 0);
    send_item(OP_PUSH, 32'shAAAA_AAAA, 0);
    send_item(OP_PUSH, 32'sd0, 0);
    repeat (4) send_item(OP_POP, 32'sd0, 0);
    drain();

    while (sent < RANDOM_ITEMS) begin
      mode  = traffic_mode_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      calm <= quiet;
      len   = $urandom_range(60, 220);
      repeat (len) send_item(pick_op(mode), pick_value(), quiet ? 0 : gap_len());
      sent += len;
      if ($urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("min_tracking_stack: match");
    end else begin
      $display("min_tracking_stack: mismatch");
    end
    $finish;
  end

endmodule
